// File: src/fbd_pkg.sv
// Shared types, constants and helper functions of the frame border detector.
package fbd_pkg;

    // Field widths
    localparam int DIM_W   = 13;
    localparam int PIX_W   = 24;
    localparam int THR_W   = 8;
    localparam int CFG_IDX_W = 1;

    // Default frame size limits (top-level parameter defaults)
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Register reset values
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1920;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1080;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'd1;

    // A pixel is content when any of the two top bits of a channel is set
    localparam logic [PIX_W-1:0] CONTENT_MASK = 24'hC0C0C0;
    localparam logic [DIM_W-1:0] COUNT_MAX    = 13'h1FFF;

    // floor(v/50) for v < 8192 as (v * 5243) >> 18
    localparam int RECIP_MUL   = 5243;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_W      = DIM_W + 13;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Input word
    typedef struct packed {
        logic [PIX_W-1:0] pixel_rgb;
        logic             frame_start;
    } pixel_in_t;

    // Result word
    typedef struct packed {
        logic [DIM_W-1:0] crop_left;
        logic [DIM_W-1:0] crop_top;
        logic [DIM_W-1:0] crop_right;
        logic [DIM_W-1:0] crop_bottom;
    } crop_out_t;

    // Classification of one pixel, handed from front to back
    typedef struct packed {
        logic clear;      // frame start: drop found markers first
        logic content;    // pixel is content
        logic first_row;  // row 0: column count is overwritten
        logic row_end;    // last column of the row
        logic last_row;   // last row of the frame
        logic row_hit;    // row count crossed the width threshold
    } fbd_flags_t;

    // Saturate a size register into 1..maxv
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int unsigned maxv);
        logic [DIM_W:0] wide_v;
        wide_v = {1'b0, v};
        if (v == '0)
            return DIM_W'(1);
        else if (32'(wide_v) > maxv)
            return DIM_W'(maxv);
        else
            return v;
    endfunction

    // floor(v/50)
    function automatic logic [THR_W-1:0] div50(input logic [DIM_W-1:0] v);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(v) * PROD_W'(RECIP_MUL);
        return prod[RECIP_SHIFT +: THR_W];
    endfunction

    // Saturating increment of a content count
    function automatic logic [DIM_W-1:0] sat_inc(input logic [DIM_W-1:0] v,
                                                 input logic c);
        if (v == COUNT_MAX)
            return v;
        else
            return v + DIM_W'(c);
    endfunction

    // Round up to even, wrapping at 13 bits
    function automatic logic [DIM_W-1:0] round_even(input logic [DIM_W-1:0] v);
        return v + DIM_W'(v[0]);
    endfunction

endpackage

// File: src/frame_border_detect.sv
// Top level of the frame border detector: config registers, front, queue, back.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    pixel_in_t  (pixel_rgb, frame_start)
//  m_        out        m_valid/m_ready    crop_out_t  (left, top, right, bottom)
//  cfg_      in         cfg_valid/ready    cfg_index, cfg_data
//
//  One pixel per clock while the queue has room. A pixel is classified in the
//  cycle it is accepted, then passes through the queue and the column-count
//  memory stage (one read port, one write port, with a same-column bypass).
//  The crop word is held in a result register. Synchronous active-low reset
//  clears position and markers; the column-count memory is not cleared (row 0
//  overwrites it). A stalled result only holds the back end when the next
//  frame's last pixel arrives.
module frame_border_detect #(
    parameter int MAX_WIDTH  = fbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fbd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // pixel input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  fbd_pkg::pixel_in_t                s_data,
    // crop result
    output logic                              m_valid,
    input  logic                              m_ready,
    output fbd_pkg::crop_out_t                m_data,
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fbd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbd_pkg::DIM_W-1:0]         cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int FLG_W = $bits(fbd_pkg::fbd_flags_t);
    localparam int Q_W   = COL_W + ROW_W + FLG_W;
    localparam int DW    = fbd_pkg::DIM_W;

    localparam logic [DW-1:0] W_CLAMP_RST = fbd_pkg::clamp_dim(fbd_pkg::WIDTH_RESET, MAX_WIDTH);
    localparam logic [DW-1:0] H_CLAMP_RST =
        fbd_pkg::clamp_dim(fbd_pkg::HEIGHT_RESET, MAX_HEIGHT);
    localparam logic [DW-1:0] W_LAST_RST = W_CLAMP_RST - DW'(1);
    localparam logic [DW-1:0] H_LAST_RST = H_CLAMP_RST - DW'(1);
    localparam logic [fbd_pkg::THR_W-1:0] W_THR_RST = fbd_pkg::div50(W_CLAMP_RST);
    localparam logic [fbd_pkg::THR_W-1:0] H_THR_RST = fbd_pkg::div50(H_CLAMP_RST);

    // Geometry registers: clamped size minus one, and size/50
    logic [DW-1:0]               width_last_reg;
    logic [DW-1:0]               height_last_reg;
    logic [fbd_pkg::THR_W-1:0]   width_thr_reg;
    logic [fbd_pkg::THR_W-1:0]   height_thr_reg;
    logic [DW-1:0]               cfg_w_clamp;
    logic [DW-1:0]               cfg_h_clamp;
    logic                        cfg_write;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign cfg_w_clamp = fbd_pkg::clamp_dim(cfg_data, MAX_WIDTH);
    assign cfg_h_clamp = fbd_pkg::clamp_dim(cfg_data, MAX_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_last_reg  <= W_LAST_RST;
            height_last_reg <= H_LAST_RST;
            width_thr_reg   <= W_THR_RST;
            height_thr_reg  <= H_THR_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                fbd_pkg::REG_ACTIVE_WIDTH: begin
                    width_last_reg <= cfg_w_clamp - DW'(1);
                    width_thr_reg  <= fbd_pkg::div50(cfg_w_clamp);
                end
                fbd_pkg::REG_ACTIVE_HEIGHT: begin
                    height_last_reg <= cfg_h_clamp - DW'(1);
                    height_thr_reg  <= fbd_pkg::div50(cfg_h_clamp);
                end
                default: begin
                end
            endcase
        end
    end

    // Front to queue
    logic                  q_push;
    logic                  q_full;
    logic [COL_W-1:0]      push_col;
    logic [ROW_W-1:0]      push_row;
    fbd_pkg::fbd_flags_t   push_flags;

    // Queue to back
    logic                  q_pop;
    logic                  head_valid;
    logic [Q_W-1:0]        head_data;
    logic [COL_W-1:0]      head_col;
    logic [ROW_W-1:0]      head_row;
    fbd_pkg::fbd_flags_t   head_flags;

    fbd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .width_last  (width_last_reg),
        .height_last (height_last_reg),
        .width_thr   (width_thr_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_col       (push_col),
        .q_row       (push_row),
        .q_flags     (push_flags)
    );

    fbd_queue #(
        .DATA_W (Q_W),
        .DEPTH  (fbd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  ({push_col, push_row, push_flags}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign {head_col, head_row, head_flags} = head_data;

    fbd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (head_valid),
        .q_col       (head_col),
        .q_row       (head_row),
        .q_flags     (head_flags),
        .q_pop       (q_pop),
        .width_last  (width_last_reg),
        .height_last (height_last_reg),
        .height_thr  (height_thr_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // A frame start word is always classified at the origin
    a_start_at_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && push_flags.clear |-> push_col == '0 && push_flags.first_row)
        else $error("frame start word not at column 0 of row 0");

    // A row is only found on its last pixel
    a_row_hit_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && push_flags.row_hit |-> push_flags.row_end)
        else $error("row found before end of row");

    // Clamped geometry stays inside the column and row range
    a_geom_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, width_last_reg} < (DW + 1)'(MAX_WIDTH) &&
        {1'b0, height_last_reg} < (DW + 1)'(MAX_HEIGHT))
        else $error("geometry register outside clamp range");

    // Pop never happens from an empty queue
    a_no_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> head_valid)
        else $error("queue popped while empty");

endmodule

// File: src/fbd_front.sv
// Front end: accepts pixels, tracks raster position and row counts, classifies.
module fbd_front #(
    parameter int MAX_WIDTH  = fbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fbd_pkg::MAX_HEIGHT_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // pixel channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  fbd_pkg::pixel_in_t            s_data,
    // frame geometry
    input  logic [fbd_pkg::DIM_W-1:0]     width_last,
    input  logic [fbd_pkg::DIM_W-1:0]     height_last,
    input  logic [fbd_pkg::THR_W-1:0]     width_thr,
    // queue write side
    input  logic                          q_full,
    output logic                          q_push,
    output logic [COL_W-1:0]              q_col,
    output logic [ROW_W-1:0]              q_row,
    output fbd_pkg::fbd_flags_t           q_flags
);

    logic [COL_W-1:0]              col_reg, col_next;
    logic [ROW_W-1:0]              row_reg, row_next;
    logic [fbd_pkg::DIM_W-1:0]     row_count_reg, row_count_next;

    logic [COL_W-1:0]              col;
    logic [ROW_W-1:0]              row;
    logic                          content;
    logic                          row_end;
    logic                          last_row;
    logic [fbd_pkg::DIM_W-1:0]     rc_new;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // Position of this pixel; frame start forces the origin
    assign col      = s_data.frame_start ? '0 : col_reg;
    assign row      = s_data.frame_start ? '0 : row_reg;
    assign content  = |(s_data.pixel_rgb & fbd_pkg::CONTENT_MASK);
    assign row_end  = fbd_pkg::DIM_W'(col) >= width_last;
    assign last_row = fbd_pkg::DIM_W'(row) >= height_last;

    // Row content count
    assign rc_new = (col == '0) ? fbd_pkg::DIM_W'(content)
                                : fbd_pkg::sat_inc(row_count_reg, content);

    always_comb begin
        q_col             = col;
        q_row             = row;
        q_flags.clear     = s_data.frame_start;
        q_flags.content   = content;
        q_flags.first_row = (row == '0);
        q_flags.row_end   = row_end;
        q_flags.last_row  = last_row;
        q_flags.row_hit   = row_end && (rc_new > fbd_pkg::DIM_W'(width_thr));
    end

    // Raster advance
    always_comb begin
        col_next       = col_reg;
        row_next       = row_reg;
        row_count_next = row_count_reg;
        if (q_push) begin
            row_count_next = rc_new;
            if (row_end && last_row) begin
                col_next = '0;
                row_next = '0;
            end else if (row_end) begin
                col_next = '0;
                row_next = row + ROW_W'(1);
            end else begin
                col_next = col + COL_W'(1);
                row_next = row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            row_count_reg <= '0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            row_count_reg <= row_count_next;
        end
    end

endmodule

// File: src/fbd_queue.sv
// Small first-in first-out queue of classified pixels between front and back.
module fbd_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = fbd_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data
);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: src/fbd_back.sv
// Back end: column count memory, found markers and the result register.
module fbd_back #(
    parameter int MAX_WIDTH  = fbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fbd_pkg::MAX_HEIGHT_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // queue read side
    input  logic                          q_valid,
    input  logic [COL_W-1:0]              q_col,
    input  logic [ROW_W-1:0]              q_row,
    input  fbd_pkg::fbd_flags_t           q_flags,
    output logic                          q_pop,
    // frame geometry
    input  logic [fbd_pkg::DIM_W-1:0]     width_last,
    input  logic [fbd_pkg::DIM_W-1:0]     height_last,
    input  logic [fbd_pkg::THR_W-1:0]     height_thr,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output fbd_pkg::crop_out_t            m_data
);

    localparam int DW = fbd_pkg::DIM_W;

    // Column count memory
    logic [DW-1:0]          col_count_mem [MAX_WIDTH];

    // Execute stage
    logic                   b_valid_reg, b_valid_next;
    logic [COL_W-1:0]       b_col_reg;
    logic [ROW_W-1:0]       b_row_reg;
    fbd_pkg::fbd_flags_t    b_flags_reg;
    logic [DW-1:0]          rd_data_reg;
    logic                   fwd_hit_reg;
    logic [DW-1:0]          fwd_val_reg;

    // Found markers
    logic                   cf_valid_reg, cf_valid_next;
    logic [COL_W-1:0]       ffc_reg, ffc_next;
    logic [COL_W-1:0]       lfc_reg, lfc_next;
    logic                   rf_valid_reg, rf_valid_next;
    logic [ROW_W-1:0]       ffr_reg, ffr_next;
    logic [ROW_W-1:0]       lfr_reg, lfr_next;

    // Result register
    logic                   m_valid_reg, m_valid_next;
    fbd_pkg::crop_out_t     m_data_reg;
    fbd_pkg::crop_out_t     result;

    logic                   b_emit;
    logic                   b_done;
    logic [DW-1:0]          base_count;
    logic [DW-1:0]          cnt;
    logic                   col_hit;
    logic                   cf_cur;
    logic                   rf_cur;
    logic [DW-1:0]          lc_clip;
    logic [DW-1:0]          lr_clip;

    // Stage handshake: a frame-ending word waits for room in the result register
    assign b_emit = b_flags_reg.row_end && b_flags_reg.last_row;
    assign b_done = b_valid_reg && (!b_emit || !m_valid_reg || m_ready);
    assign q_pop  = q_valid && (!b_valid_reg || b_done);

    // Column count update, with bypass of a write to the same column
    assign base_count = fwd_hit_reg ? fwd_val_reg : rd_data_reg;
    assign cnt = b_flags_reg.first_row ? DW'(b_flags_reg.content)
                                       : fbd_pkg::sat_inc(base_count, b_flags_reg.content);
    assign col_hit = b_flags_reg.last_row && (cnt > DW'(height_thr));

    // Marker update
    always_comb begin
        cf_cur        = b_flags_reg.clear ? 1'b0 : cf_valid_reg;
        rf_cur        = b_flags_reg.clear ? 1'b0 : rf_valid_reg;
        cf_valid_next = cf_cur;
        ffc_next      = ffc_reg;
        lfc_next      = lfc_reg;
        rf_valid_next = rf_cur;
        ffr_next      = ffr_reg;
        lfr_next      = lfr_reg;
        if (col_hit) begin
            if (!cf_cur)
                ffc_next = b_col_reg;
            lfc_next      = b_col_reg;
            cf_valid_next = 1'b1;
        end
        if (b_flags_reg.row_hit) begin
            if (!rf_cur)
                ffr_next = b_row_reg;
            lfr_next      = b_row_reg;
            rf_valid_next = 1'b1;
        end
    end

    // Crop values from the updated markers
    always_comb begin
        lc_clip = (DW'(lfc_next) > width_last)  ? width_last  : DW'(lfc_next);
        lr_clip = (DW'(lfr_next) > height_last) ? height_last : DW'(lfr_next);
        result.crop_left   = cf_valid_next ? fbd_pkg::round_even(DW'(ffc_next)) : '0;
        result.crop_top    = rf_valid_next ? fbd_pkg::round_even(DW'(ffr_next)) : '0;
        result.crop_right  = cf_valid_next ? fbd_pkg::round_even(width_last - lc_clip) : '0;
        result.crop_bottom = rf_valid_next ? fbd_pkg::round_even(height_last - lr_clip) : '0;
    end

    always_comb begin
        b_valid_next = b_valid_reg;
        if (q_pop)
            b_valid_next = 1'b1;
        else if (b_done)
            b_valid_next = 1'b0;
        m_valid_next = m_valid_reg;
        if (b_done && b_emit)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            cf_valid_reg <= 1'b0;
            rf_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
            if (b_done) begin
                // frame end clears the markers for the next frame
                cf_valid_reg <= b_emit ? 1'b0 : cf_valid_next;
                rf_valid_reg <= b_emit ? 1'b0 : rf_valid_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b_col_reg   <= q_col;
            b_row_reg   <= q_row;
            b_flags_reg <= q_flags;
            fwd_hit_reg <= b_done && (b_col_reg == q_col);
            fwd_val_reg <= cnt;
        end
        if (b_done) begin
            ffc_reg <= ffc_next;
            lfc_reg <= lfc_next;
            ffr_reg <= ffr_next;
            lfr_reg <= lfr_next;
        end
        if (b_done && b_emit)
            m_data_reg <= result;
    end

    // Memory: read at dispatch, write when the stage retires
    always_ff @(posedge aclk) begin
        if (q_pop)
            rd_data_reg <= col_count_mem[q_col];
        if (b_done)
            col_count_mem[b_col_reg] <= cnt;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
